// ===== rtl/gsv_pkg.sv =====
// Shared constants, types and helper functions of the shadowcast visibility unit.
// Depends on nothing; every other file but gsv_div refers to it by scoped names.
package gsv_pkg;

	// grid and frame queue sizing
	localparam int GRID_SIZE   = 128;
	localparam int QUEUE_DEPTH = 256;

	localparam int GRID_W = $clog2(GRID_SIZE);
	localparam int CELLS  = GRID_SIZE * GRID_SIZE;
	localparam int IDX_W  = $clog2(CELLS);
	localparam int QA_W   = $clog2(QUEUE_DEPTH);
	localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

	// signed cell coordinate: origin plus or minus one full radius
	localparam int CW = (GRID_W + 2 > 10) ? GRID_W + 2 : 10;
	// slope terms reach 2*127+1
	localparam int SW = 10;
	// row and distance, up to radius+1
	localparam int RW = 8;

	// command codes
	localparam logic [2:0] CMD_WRITE   = 3'd0;
	localparam logic [2:0] CMD_CLRMAP  = 3'd1;
	localparam logic [2:0] CMD_CLRVIEW = 3'd2;
	localparam logic [2:0] CMD_CAST    = 3'd3;
	localparam logic [2:0] CMD_READ    = 3'd4;

	localparam logic [7:0] BRIGHT_MAX = 8'd255;

	// octant transform entries
	localparam logic signed [1:0] MP = 2'sb01;
	localparam logic signed [1:0] MN = 2'sb11;
	localparam logic signed [1:0] MZ = 2'sb00;

	localparam logic signed [1:0] OCT_M [8][4] = '{
		'{MZ, MP, MP, MZ},
		'{MP, MZ, MZ, MP},
		'{MZ, MN, MP, MZ},
		'{MN, MZ, MZ, MP},
		'{MZ, MP, MN, MZ},
		'{MP, MZ, MZ, MN},
		'{MZ, MN, MN, MZ},
		'{MN, MZ, MZ, MN}
	};

	// one pending frame: start row, high slope hy/hx, low slope ly/lx
	typedef struct packed {
		logic [RW-1:0]        row;
		logic signed [SW-1:0] hy;
		logic signed [SW-1:0] hx;
		logic signed [SW-1:0] ly;
		logic signed [SW-1:0] lx;
	} frame_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic sweep_all;
		logic sweep_b;
		logic sweep_v;
		logic origin;
		logic oct_init;
		logic oct_next;
		logic row_init;
		logic div_start;
		logic dy_init;
		logic visit;
		logic decide;
		logic row_end;
		logic dy_dec;
		logic pop;
		logic load;
		logic post;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic sweep_last;
		logic frame_empty;
		logic row_done;
		logic div_done;
		logic skip;
		logic brk;
		logic dy_zero;
		logic q_empty;
		logic oct_last;
		logic s1_free;
	} st_t;

	// sign test of bx*ay - ax*by
	function automatic logic slope_lt(input logic signed [SW-1:0] ay,
			input logic signed [SW-1:0] ax, input logic signed [SW-1:0] by,
			input logic signed [SW-1:0] bx);
		logic signed [2*SW:0] c;
		c = bx * ay - ax * by;
		return c[2*SW];
	endfunction

	function automatic logic slope_gt(input logic signed [SW-1:0] ay,
			input logic signed [SW-1:0] ax, input logic signed [SW-1:0] by,
			input logic signed [SW-1:0] bx);
		logic signed [2*SW:0] c;
		c = bx * ay - ax * by;
		return !c[2*SW] && (c != '0);
	endfunction

	// multiply by a transform entry of 0, +1 or -1
	function automatic logic signed [CW-1:0] sel_mul(input logic signed [CW-1:0] v,
			input logic signed [1:0] m);
		logic signed [CW-1:0] r;
		case (m)
			MP:      r = v;
			MN:      r = -v;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] cell_idx(input logic [GRID_W-1:0] x,
			input logic [GRID_W-1:0] y);
		return IDX_W'(IDX_W'(x) * IDX_W'(GRID_SIZE) + IDX_W'(y));
	endfunction

endpackage

// ===== rtl/grid_shadowcast_visibility_unit.sv =====
// Top level of the shadowcast visibility unit: controller plus datapath.
// Depends on gsv_pkg, gsv_ctrl, gsv_dp (which holds gsv_div).
//
// channel | handshake            | payload
// cmd     | cmd_valid, cmd_stall | command, cell_x, cell_y, radius, block_value
// rsp     | rsp_valid, rsp_stall | brightness, blocked, status
//
// Write, read, unknown: one per cycle unless rsp stalls; registered in s1, then output.
// Clear map and clear view: one cell per cycle over all 16384 cells.
// Cast: a frame row costs a row check and divider steps, a visited cell a visit and
// a decision, a skipped or stopping cell only its evaluation, a frame a pop, load,
// check, plus a row check if not empty; the divider and single memory ports set this.
// After reset one sweep clears both grids, all 16384 cells; cmd_stall is high meanwhile.
// cmd_stall is also high while a result waits behind a stalled rsp register.
module grid_shadowcast_visibility_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [2:0] command,
	input  logic [6:0] cell_x,
	input  logic [6:0] cell_y,
	input  logic [6:0] radius,
	input  logic       block_value,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [7:0] brightness,
	output logic       blocked,
	output logic       status
);

	gsv_pkg::ctl_t ctl;
	gsv_pkg::st_t  st;

	gsv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (command),
		.st        (st),
		.cmd_stall (cmd_stall),
		.ctl       (ctl)
	);

	gsv_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (command),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.radius      (radius),
		.block_value (block_value),
		.ctl         (ctl),
		.st          (st),
		.rsp_stall   (rsp_stall),
		.rsp_valid   (rsp_valid),
		.brightness  (brightness),
		.blocked     (blocked),
		.status      (status)
	);

	// a block decision always follows the visit that read its bit
	a_decide_after_visit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.decide |-> $past(ctl.visit))
		else $error("decide without preceding visit");

	// no frame is taken from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> !st.q_empty)
		else $error("pop from empty frame queue");

	// a finished long command never overwrites a pending result
	a_post_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.post |-> st.s1_free && !ctl.accept)
		else $error("result posted over pending result");

endmodule

// ===== rtl/gsv_div.sv =====
// Restoring divider: floor(255*d / r) for 1 <= d <= r, one quotient bit a cycle.
// Depends on nothing but its ports.
module gsv_div (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] dvd,
	input  logic [6:0] dvs,
	output logic [7:0] quo,
	output logic       done
);

	logic [14:0] rem_q;
	logic [7:0]  quo_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic [15:0] prod;
	logic [14:0] trial;
	logic        ge;

	// 255*d as (d<<8)-d; quotient stays below 256 since d <= r
	assign prod  = {dvd, 8'h00} - {8'h00, dvd};
	assign trial = 15'(dvs) << cnt_q;
	assign ge    = rem_q >= trial;
	assign done  = busy_q && (cnt_q == 3'd0);
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd7;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 3'd1;
			if (cnt_q == 3'd0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= prod[14:0];
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - trial;
			quo_q <= {quo_q[6:0], ge};
		end
	end

endmodule

// ===== rtl/gsv_dp.sv =====
// Datapath: block and view memories, frame queue, cast registers, result stages.
// Depends on gsv_pkg and gsv_div.
module gsv_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [2:0]    command,
	input  logic [6:0]    cell_x,
	input  logic [6:0]    cell_y,
	input  logic [6:0]    radius,
	input  logic          block_value,
	input  gsv_pkg::ctl_t ctl,
	output gsv_pkg::st_t  st,
	input  logic          rsp_stall,
	output logic          rsp_valid,
	output logic [7:0]    brightness,
	output logic          blocked,
	output logic          status
);

	localparam int IDX_W = gsv_pkg::IDX_W;
	localparam int CW    = gsv_pkg::CW;
	localparam int SW    = gsv_pkg::SW;
	localparam int RW    = gsv_pkg::RW;
	localparam int QA_W  = gsv_pkg::QA_W;
	localparam int QC_W  = gsv_pkg::QC_W;
	localparam int GW    = gsv_pkg::GRID_W;

	// memories
	logic                bmem [gsv_pkg::CELLS];
	logic [7:0]          vmem [gsv_pkg::CELLS];
	gsv_pkg::frame_t     qmem [gsv_pkg::QUEUE_DEPTH];

	// cast registers
	logic [6:0]           ox_q, oy_q, rad_q;
	logic                 cast_q, ov_q, shadow_q;
	logic [2:0]           oct_q;
	gsv_pkg::frame_t      fr_q;
	logic [RW-1:0]        d_q, dy_q;
	logic signed [SW-1:0] ns_y_q, ns_x_q;
	logic [QA_W-1:0]      head_q;
	logic [QC_W-1:0]      cnt_q;
	logic [IDX_W-1:0]     sw_q;

	// memory ports
	logic             bm_we, bm_wd, bm_re, bm_rd_q;
	logic [IDX_W-1:0] bm_wa, bm_ra;
	logic             vm_we, vm_re;
	logic [IDX_W-1:0] vm_wa;
	logic [7:0]       vm_wd, vm_rd_q;
	logic             q_we;
	logic [QA_W-1:0]  q_wa;
	gsv_pkg::frame_t  q_wd, q_rd_q;

	// result stages
	logic       s1_valid_q, s1_read_q, s1_status_q;
	logic       out_valid_q, out_blk_q, out_st_q;
	logic [7:0] out_br_q;
	logic       move;

	// combinational helpers
	logic                 p_grid, o_grid, c_grid, is_short, solid, push_try, push;
	logic [IDX_W-1:0]     p_idx, o_idx, c_idx;
	logic signed [CW-1:0] dxs, dys, oxs, oys, cx, cy;
	logic signed [SW-1:0] dx2, dy2, lft_y, lft_x, rgt_y, rgt_x;
	logic [7:0]           div_q, bright;
	logic                 div_done;
	logic [QC_W:0]        slot_sum, head_sum;

	gsv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.dvd    (d_q),
		.dvs    (rad_q),
		.quo    (div_q),
		.done   (div_done)
	);

	// port cell address
	assign p_grid = (32'(cell_x) < 32'(gsv_pkg::GRID_SIZE)) &&
	                (32'(cell_y) < 32'(gsv_pkg::GRID_SIZE));
	assign p_idx  = gsv_pkg::cell_idx(GW'(cell_x), GW'(cell_y));
	assign o_grid = (32'(ox_q) < 32'(gsv_pkg::GRID_SIZE)) &&
	                (32'(oy_q) < 32'(gsv_pkg::GRID_SIZE));
	assign o_idx  = gsv_pkg::cell_idx(GW'(ox_q), GW'(oy_q));
	assign is_short = (command != gsv_pkg::CMD_CLRMAP) &&
	                  (command != gsv_pkg::CMD_CLRVIEW) &&
	                  (command != gsv_pkg::CMD_CAST);

	// current cell of the walk
	assign dxs = $signed(CW'(d_q));
	assign dys = $signed(CW'(dy_q));
	assign oxs = $signed(CW'(ox_q));
	assign oys = $signed(CW'(oy_q));
	assign cx  = oxs + gsv_pkg::sel_mul(dxs, gsv_pkg::OCT_M[oct_q][0])
	                 + gsv_pkg::sel_mul(dys, gsv_pkg::OCT_M[oct_q][1]);
	assign cy  = oys + gsv_pkg::sel_mul(dxs, gsv_pkg::OCT_M[oct_q][2])
	                 + gsv_pkg::sel_mul(dys, gsv_pkg::OCT_M[oct_q][3]);
	assign c_grid = !cx[CW-1] && !cy[CW-1] &&
	                ($unsigned(cx) < CW'(gsv_pkg::GRID_SIZE)) &&
	                ($unsigned(cy) < CW'(gsv_pkg::GRID_SIZE));
	assign c_idx  = gsv_pkg::cell_idx(GW'(cx), GW'(cy));

	// cell edge slopes
	assign dx2   = $signed(SW'({d_q, 1'b0}));
	assign dy2   = $signed(SW'({dy_q, 1'b0}));
	assign lft_y = dy2 + $signed(SW'(1));
	assign lft_x = dx2 - $signed(SW'(1));
	assign rgt_y = dy2 - $signed(SW'(1));
	assign rgt_x = dx2 + $signed(SW'(1));

	assign bright = gsv_pkg::BRIGHT_MAX - div_q;
	assign solid  = bm_rd_q;

	// queue slots, wrapped at the depth
	always_comb begin
		slot_sum = (QC_W+1)'(head_q) + (QC_W+1)'(cnt_q);
		if (slot_sum >= (QC_W+1)'(gsv_pkg::QUEUE_DEPTH))
			slot_sum = slot_sum - (QC_W+1)'(gsv_pkg::QUEUE_DEPTH);
		head_sum = (QC_W+1)'(head_q) + (QC_W+1)'(1);
		if (head_sum >= (QC_W+1)'(gsv_pkg::QUEUE_DEPTH))
			head_sum = '0;
	end

	assign push_try = ctl.decide && !shadow_q && solid && (d_q < {1'b0, rad_q});
	assign push     = push_try && (cnt_q < QC_W'(gsv_pkg::QUEUE_DEPTH));

	// block memory port select
	always_comb begin
		bm_we = 1'b0;
		bm_wa = p_idx;
		bm_wd = block_value;
		if (ctl.sweep_all || ctl.sweep_b) begin
			bm_we = 1'b1;
			bm_wa = sw_q;
			bm_wd = 1'b0;
		end else if (ctl.accept && command == gsv_pkg::CMD_WRITE && p_grid) begin
			bm_we = 1'b1;
		end
		bm_re = ctl.visit || (ctl.accept && command == gsv_pkg::CMD_READ);
		bm_ra = ctl.visit ? c_idx : p_idx;
	end

	// view memory port select
	always_comb begin
		vm_we = 1'b0;
		vm_wa = sw_q;
		vm_wd = '0;
		if (ctl.sweep_all || ctl.sweep_v) begin
			vm_we = 1'b1;
		end else if (ctl.origin && o_grid) begin
			vm_we = 1'b1;
			vm_wa = o_idx;
			vm_wd = gsv_pkg::BRIGHT_MAX;
		end else if (ctl.visit) begin
			vm_we = 1'b1;
			vm_wa = c_idx;
			vm_wd = bright;
		end
		vm_re = ctl.accept && command == gsv_pkg::CMD_READ;
	end

	assign q_we = push;
	assign q_wa = QA_W'(slot_sum);
	assign q_wd = '{row: d_q + RW'(1), hy: fr_q.hy, hx: fr_q.hx, ly: lft_y, lx: lft_x};

	always_ff @(posedge clk) begin
		if (bm_we)
			bmem[bm_wa] <= bm_wd;
		if (bm_re)
			bm_rd_q <= bmem[bm_ra];
	end

	always_ff @(posedge clk) begin
		if (vm_we)
			vmem[vm_wa] <= vm_wd;
		if (vm_re)
			vm_rd_q <= vmem[p_idx];
	end

	always_ff @(posedge clk) begin
		if (q_we)
			qmem[q_wa] <= q_wd;
		if (ctl.pop)
			q_rd_q <= qmem[head_q];
	end

	// sweep counter, wraps so the next sweep starts at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= '0;
		end else if (ctl.sweep_all || ctl.sweep_b || ctl.sweep_v) begin
			if (sw_q == IDX_W'(gsv_pkg::CELLS - 1))
				sw_q <= '0;
			else
				sw_q <= sw_q + IDX_W'(1);
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else if (ctl.oct_init) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else if (ctl.pop) begin
			head_q <= QA_W'(head_sum);
			cnt_q  <= cnt_q - QC_W'(1);
		end else if (push) begin
			cnt_q <= cnt_q + QC_W'(1);
		end
	end

	// cast parameters and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cast_q <= 1'b0;
			ov_q   <= 1'b0;
			oct_q  <= '0;
		end else begin
			if (ctl.accept)
				cast_q <= command == gsv_pkg::CMD_CAST;
			if (ctl.origin) begin
				ov_q  <= 1'b0;
				oct_q <= '0;
			end else begin
				if (push_try && !push)
					ov_q <= 1'b1;
				if (ctl.oct_next)
					oct_q <= oct_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			ox_q  <= cell_x;
			oy_q  <= cell_y;
			rad_q <= radius;
		end
	end

	// frame, row and cell walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_q <= 1'b0;
		end else if (ctl.row_init) begin
			shadow_q <= 1'b0;
		end else if (ctl.decide) begin
			if (shadow_q && !solid)
				shadow_q <= 1'b0;
			else if (push_try)
				shadow_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.oct_init) begin
			fr_q <= '{row: RW'(1), hy: SW'(1), hx: SW'(1), ly: '0, lx: SW'(1)};
		end else if (ctl.load) begin
			fr_q <= q_rd_q;
		end else if (ctl.decide && shadow_q && !solid) begin
			// leaving the shadow: narrow the high slope
			fr_q.hy <= ns_y_q;
			fr_q.hx <= ns_x_q;
		end
		if (ctl.row_init) begin
			ns_y_q <= '0;
			ns_x_q <= '0;
		end else if (ctl.decide && solid && (shadow_q || push_try)) begin
			ns_y_q <= rgt_y;
			ns_x_q <= rgt_x;
		end
		if (ctl.row_init)
			d_q <= fr_q.row;
		else if (ctl.row_end)
			d_q <= d_q + RW'(1);
		if (ctl.dy_init)
			dy_q <= d_q;
		else if (ctl.dy_dec)
			dy_q <= dy_q - RW'(1);
	end

	// result stage s1, then the output register
	assign move = s1_valid_q && (!out_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((ctl.accept && is_short) || ctl.post)
				s1_valid_q <= 1'b1;
			else if (move)
				s1_valid_q <= 1'b0;
			if (move)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && is_short) begin
			s1_read_q   <= (command == gsv_pkg::CMD_READ) && p_grid;
			s1_status_q <= 1'b0;
		end else if (ctl.post) begin
			s1_read_q   <= 1'b0;
			s1_status_q <= cast_q && ov_q;
		end
		if (move) begin
			out_br_q  <= s1_read_q ? vm_rd_q : 8'd0;
			out_blk_q <= s1_read_q && bm_rd_q;
			out_st_q  <= s1_status_q;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign brightness = out_br_q;
	assign blocked    = out_blk_q;
	assign status     = out_st_q;

	// status to the controller
	assign st.sweep_last  = sw_q == IDX_W'(gsv_pkg::CELLS - 1);
	assign st.frame_empty = gsv_pkg::slope_lt(fr_q.hy, fr_q.hx, fr_q.ly, fr_q.lx);
	assign st.row_done    = (d_q > {1'b0, rad_q}) || shadow_q;
	assign st.div_done    = div_done;
	assign st.skip        = gsv_pkg::slope_lt(fr_q.hy, fr_q.hx, rgt_y, rgt_x) || !c_grid;
	assign st.brk         = gsv_pkg::slope_gt(fr_q.ly, fr_q.lx, lft_y, lft_x);
	assign st.dy_zero     = dy_q == '0;
	assign st.q_empty     = cnt_q == '0;
	assign st.oct_last    = oct_q == 3'd7;
	assign st.s1_free     = !s1_valid_q || move;

endmodule

// ===== rtl/gsv_ctrl.sv =====
// Controller state machine: command dispatch, clearing sweeps and the cast walk.
// Depends on gsv_pkg.
module gsv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic [2:0]    command,
	input  gsv_pkg::st_t  st,
	output logic          cmd_stall,
	output gsv_pkg::ctl_t ctl
);

	localparam logic [3:0] S_RSTCLR = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_CLRB   = 4'd2;
	localparam logic [3:0] S_CLRV   = 4'd3;
	localparam logic [3:0] S_ORIGIN = 4'd4;
	localparam logic [3:0] S_OCT    = 4'd5;
	localparam logic [3:0] S_FCHK   = 4'd6;
	localparam logic [3:0] S_ROW    = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_EVAL   = 4'd9;
	localparam logic [3:0] S_DEC    = 4'd10;
	localparam logic [3:0] S_NEXT   = 4'd11;
	localparam logic [3:0] S_LOAD   = 4'd12;
	localparam logic [3:0] S_FIN    = 4'd13;

	logic [3:0] state_q, state_nxt;
	logic       acc;

	assign cmd_stall = !((state_q == S_IDLE) && st.s1_free);
	assign acc       = cmd_valid && !cmd_stall;

	// next state and datapath commands
	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		case (state_q)
			S_RSTCLR: begin
				ctl.sweep_all = 1'b1;
				if (st.sweep_last)
					state_nxt = S_IDLE;
			end
			S_IDLE: begin
				ctl.accept = acc;
				if (acc) begin
					case (command)
						gsv_pkg::CMD_CLRMAP:  state_nxt = S_CLRB;
						gsv_pkg::CMD_CLRVIEW: state_nxt = S_CLRV;
						gsv_pkg::CMD_CAST:    state_nxt = S_ORIGIN;
						default:              state_nxt = S_IDLE;
					endcase
				end
			end
			S_CLRB: begin
				ctl.sweep_b = 1'b1;
				if (st.sweep_last)
					state_nxt = S_FIN;
			end
			S_CLRV: begin
				ctl.sweep_v = 1'b1;
				if (st.sweep_last)
					state_nxt = S_FIN;
			end
			S_ORIGIN: begin
				ctl.origin = 1'b1;
				state_nxt  = S_OCT;
			end
			S_OCT: begin
				ctl.oct_init = 1'b1;
				state_nxt    = S_FCHK;
			end
			S_FCHK: begin
				if (st.frame_empty) begin
					state_nxt = S_NEXT;
				end else begin
					ctl.row_init = 1'b1;
					state_nxt    = S_ROW;
				end
			end
			S_ROW: begin
				if (st.row_done) begin
					state_nxt = S_NEXT;
				end else begin
					ctl.div_start = 1'b1;
					state_nxt     = S_DIV;
				end
			end
			S_DIV: begin
				if (st.div_done) begin
					ctl.dy_init = 1'b1;
					state_nxt   = S_EVAL;
				end
			end
			S_EVAL: begin
				if (st.skip) begin
					if (st.dy_zero) begin
						ctl.row_end = 1'b1;
						state_nxt   = S_ROW;
					end else begin
						ctl.dy_dec = 1'b1;
					end
				end else if (st.brk) begin
					ctl.row_end = 1'b1;
					state_nxt   = S_ROW;
				end else begin
					ctl.visit = 1'b1;
					state_nxt = S_DEC;
				end
			end
			S_DEC: begin
				ctl.decide = 1'b1;
				if (st.dy_zero) begin
					ctl.row_end = 1'b1;
					state_nxt   = S_ROW;
				end else begin
					ctl.dy_dec = 1'b1;
					state_nxt  = S_EVAL;
				end
			end
			S_NEXT: begin
				if (!st.q_empty) begin
					ctl.pop   = 1'b1;
					state_nxt = S_LOAD;
				end else if (st.oct_last) begin
					state_nxt = S_FIN;
				end else begin
					ctl.oct_next = 1'b1;
					state_nxt    = S_OCT;
				end
			end
			S_LOAD: begin
				ctl.load  = 1'b1;
				state_nxt = S_FCHK;
			end
			S_FIN: begin
				if (st.s1_free) begin
					ctl.post  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_RSTCLR;
		else
			state_q <= state_nxt;
	end

endmodule

// ===== sim/grid_shadowcast_visibility_unit_tb.sv =====
// Self-checking testbench of grid_shadowcast_visibility_unit: directed and random commands,
// with every result checked against a behavioral shadowcast predictor kept in the bench.
// Depends on gsv_pkg (command codes and sizes) and the unit's RTL.
`timescale 1ns / 100ps

module grid_shadowcast_visibility_unit_tb;

	localparam int N_SIDE      = gsv_pkg::GRID_SIZE;
	localparam int N_FRAMES    = gsv_pkg::QUEUE_DEPTH;
	localparam int CYCLE_LIMIT = 40_000_000;
	localparam int N_RANDOM    = 800;
	localparam int N_QUIET     = 150;

	// unknown command codes
	localparam logic [2:0] CMD_BAD5 = 3'd5;
	localparam logic [2:0] CMD_BAD6 = 3'd6;
	localparam logic [2:0] CMD_BAD7 = 3'd7;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	logic [2:0] command = '0;
	logic [6:0] cell_x = '0;
	logic [6:0] cell_y = '0;
	logic [6:0] radius = '0;
	logic       block_value = 1'b0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	logic [7:0] brightness;
	logic       blocked;
	logic       status;

	typedef struct packed {
		logic [7:0] brightness;
		logic       blocked;
		logic       status;
	} answer_t;

	answer_t answers_due[$];

	// bench copy of the grids and of the frame queue
	bit            blk_grid [N_SIDE*N_SIDE];
	byte unsigned  lit_grid [N_SIDE*N_SIDE];
	int            fq_row [N_FRAMES];
	int            fq_hy  [N_FRAMES];
	int            fq_hx  [N_FRAMES];
	int            fq_ly  [N_FRAMES];
	int            fq_lx  [N_FRAMES];
	int            fq_head, fq_count;
	bit            fq_overflow;

	int  octant_tab [8][4] = '{
		'{ 0, 1, 1, 0}, '{ 1, 0, 0, 1}, '{ 0,-1, 1, 0}, '{-1, 0, 0, 1},
		'{ 0, 1,-1, 0}, '{ 1, 0, 0,-1}, '{ 0,-1,-1, 0}, '{-1, 0, 0,-1}
	};

	int  mismatches = 0;
	int  n_accepted = 0;
	int  n_checked = 0;
	int  n_casts = 0;
	int  n_overflows = 0;
	int  n_clears = 0;
	int  cycles = 0;
	bit  idle_on = 1'b1;

	grid_shadowcast_visibility_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.command(command), .cell_x(cell_x), .cell_y(cell_y),
		.radius(radius), .block_value(block_value),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.brightness(brightness), .blocked(blocked), .status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// global watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				answers_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// sign of bx*ay - ax*by
	function automatic int slope_sign(int ay, int ax, int by, int bx);
		int c;
		c = bx * ay - ax * by;
		return (c > 0) - (c < 0);
	endfunction

	function automatic bit in_grid(int x, int y);
		return x >= 0 && y >= 0 && x < N_SIDE && y < N_SIDE;
	endfunction

	task automatic frame_push(int row, int hy, int hx, int ly, int lx);
		int slot;
		if (fq_count >= N_FRAMES) begin
			fq_overflow = 1'b1;
			return;
		end
		slot = (fq_head + fq_count) % N_FRAMES;
		fq_row[slot] = row;
		fq_hy[slot] = hy;
		fq_hx[slot] = hx;
		fq_ly[slot] = ly;
		fq_lx[slot] = lx;
		fq_count++;
	endtask

	// one octant of the shadowcast, breadth first over pending frames
	task automatic light_octant(int ox, int oy, int r, int oc);
		int row, hy, hx, ly, lx;
		int nsy, nsx, d, dx, dy, cx, cy, idx, b;
		int lfy, lfx, rty, rtx;
		bit shadow, solid;
		fq_head = 0;
		fq_count = 0;
		frame_push(1, 1, 1, 0, 1);
		while (fq_count > 0) begin
			row = fq_row[fq_head];
			hy = fq_hy[fq_head];
			hx = fq_hx[fq_head];
			ly = fq_ly[fq_head];
			lx = fq_lx[fq_head];
			fq_head = (fq_head + 1) % N_FRAMES;
			fq_count--;
			if (slope_sign(hy, hx, ly, lx) < 0)
				continue;
			shadow = 1'b0;
			nsy = 0;
			nsx = 0;
			for (d = row; d <= r && !shadow; d++) begin
				dx = d;
				for (dy = d; dy >= 0; dy--) begin
					cx = ox + dx * octant_tab[oc][0] + dy * octant_tab[oc][1];
					cy = oy + dx * octant_tab[oc][2] + dy * octant_tab[oc][3];
					lfy = 2 * dy + 1;
					lfx = 2 * dx - 1;
					rty = 2 * dy - 1;
					rtx = 2 * dx + 1;
					if (slope_sign(hy, hx, rty, rtx) < 0 || !in_grid(cx, cy))
						continue;
					if (slope_sign(ly, lx, lfy, lfx) > 0)
						break;
					idx = cx * N_SIDE + cy;
					b = 255 - (255 * d) / r;
					if (b < 0)
						b = 0;
					lit_grid[idx] = 8'(b);
					solid = blk_grid[idx];
					if (shadow) begin
						if (solid) begin
							nsy = rty;
							nsx = rtx;
							continue;
						end
						shadow = 1'b0;
						hy = nsy;
						hx = nsx;
					end else if (solid && d < r) begin
						shadow = 1'b1;
						frame_push(d + 1, hy, hx, lfy, lfx);
						nsy = rty;
						nsx = rtx;
					end
				end
			end
		end
		fq_head = 0;
	endtask

	// expected answer of one accepted command; updates the bench grids
	task automatic predict_answer(logic [2:0] cmd, int x, int y, int r, bit bv,
			output answer_t a);
		a = '0;
		case (cmd)
			gsv_pkg::CMD_WRITE: blk_grid[x*N_SIDE+y] = bv;
			gsv_pkg::CMD_CLRMAP: foreach (blk_grid[i]) blk_grid[i] = 1'b0;
			gsv_pkg::CMD_CLRVIEW: foreach (lit_grid[i]) lit_grid[i] = 8'd0;
			gsv_pkg::CMD_CAST: begin
				fq_overflow = 1'b0;
				lit_grid[x*N_SIDE+y] = 8'd255;
				for (int o = 0; o < 8; o++)
					light_octant(x, y, r, o);
				a.status = fq_overflow;
			end
			gsv_pkg::CMD_READ: begin
				a.brightness = lit_grid[x*N_SIDE+y];
				a.blocked = blk_grid[x*N_SIDE+y];
			end
			default: ;
		endcase
	endtask

	// command side monitor: predict on every accepted transaction
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && cmd_valid && !cmd_stall) begin
			predict_answer(command, int'(cell_x), int'(cell_y), int'(radius), block_value, a);
			answers_due.push_back(a);
			n_accepted++;
			if (command == gsv_pkg::CMD_CAST) begin
				n_casts++;
				if (a.status)
					n_overflows++;
			end
		end
	end

	// result side checker
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: bright=%0d blk=%0d st=%0d",
						brightness, blocked, status);
			end else begin
				e = answers_due.pop_front();
				n_checked++;
				if (brightness !== e.brightness || blocked !== e.blocked
						|| status !== e.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: exp bright=%0d blk=%0d st=%0d, got %0d %0d %0d",
							n_checked, e.brightness, e.blocked, e.status,
							brightness, blocked, status);
				end
			end
		end
	end

	// result side backpressure in random bursts
	always @(posedge clk) begin
		static int burst = 0;
		if (burst > 0) begin
			rsp_stall <= 1'b1;
			burst--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			burst = $urandom_range(0, 6);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// drive one command transaction and wait until it is taken
	task automatic send_cmd(logic [2:0] cmd, int x, int y, int r, bit bv);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= cmd;
		cell_x <= 7'(x);
		cell_y <= 7'(y);
		radius <= 7'(r);
		block_value <= bv;
		do
			@(posedge clk);
		while (cmd_stall);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	// field extremes, every command, unknown codes, radius zero, corner casts
	task automatic test_directed();
		send_cmd(gsv_pkg::CMD_WRITE, 0, 0, 0, 1);
		send_cmd(gsv_pkg::CMD_WRITE, 127, 127, 127, 1);
		send_cmd(gsv_pkg::CMD_READ, 0, 0, 0, 0);
		send_cmd(gsv_pkg::CMD_READ, 127, 127, 0, 0);
		send_cmd(gsv_pkg::CMD_READ, 64, 64, 0, 0);
		send_cmd(gsv_pkg::CMD_CAST, 0, 0, 0, 0);
		send_cmd(gsv_pkg::CMD_READ, 0, 0, 0, 0);
		send_cmd(gsv_pkg::CMD_READ, 1, 0, 0, 0);
		send_cmd(gsv_pkg::CMD_CAST, 127, 127, 127, 0);
		send_cmd(gsv_pkg::CMD_READ, 127, 0, 0, 0);
		send_cmd(gsv_pkg::CMD_READ, 126, 126, 0, 0);
		send_cmd(CMD_BAD5, 127, 127, 127, 1);
		send_cmd(CMD_BAD6, 0, 0, 0, 0);
		send_cmd(CMD_BAD7, 127, 127, 127, 1);
		send_cmd(gsv_pkg::CMD_CLRVIEW, 0, 0, 0, 0);
		send_cmd(gsv_pkg::CMD_READ, 126, 126, 0, 0);
		send_cmd(gsv_pkg::CMD_CLRMAP, 127, 127, 127, 1);
		send_cmd(gsv_pkg::CMD_READ, 127, 127, 0, 0);
		send_cmd(gsv_pkg::CMD_WRITE, 65, 64, 0, 1);
		send_cmd(gsv_pkg::CMD_CAST, 64, 64, 1, 0);
		send_cmd(gsv_pkg::CMD_CAST, 64, 64, 6, 1);
		send_cmd(gsv_pkg::CMD_READ, 66, 64, 0, 0);
		send_cmd(gsv_pkg::CMD_READ, 64, 70, 0, 0);
		send_cmd(gsv_pkg::CMD_CAST, 64, 64, 127, 0);
		send_cmd(gsv_pkg::CMD_READ, 0, 127, 0, 0);
		n_clears += 2;
	endtask

	// dense lattice of blockers so the frame queue fills up
	task automatic test_queue_overflow();
		for (int i = -5; i <= 5; i++)
			for (int j = -5; j <= 5; j++)
				if (i != 0 || j != 0)
					send_cmd(gsv_pkg::CMD_WRITE, 40 + 2*i, 40 + 2*j, 0, 1);
		send_cmd(gsv_pkg::CMD_CAST, 40, 40, 30, 0);
		send_cmd(gsv_pkg::CMD_READ, 43, 41, 0, 0);
		wait_drained();
		send_cmd(gsv_pkg::CMD_CLRMAP, 0, 0, 0, 0);
		n_clears++;
	endtask

	// random commands clustered around a moving center
	task automatic test_random(int n);
		int cx, cy, x, y, r, pick;
		logic [2:0] cmd;
		cx = $urandom_range(0, 127);
		cy = $urandom_range(0, 127);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 60) == 0) begin
				cx = $urandom_range(0, 127);
				cy = $urandom_range(0, 127);
			end
			if ($urandom_range(0, 4) == 0) begin
				x = $urandom_range(0, 127);
				y = $urandom_range(0, 127);
			end else begin
				x = (cx + $urandom_range(0, 15)) % N_SIDE;
				y = (cy + $urandom_range(0, 15)) % N_SIDE;
			end
			r = ($urandom_range(0, 30) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 10);
			if (r > 40 && n_casts > 20)
				r = r % 12;
			pick = $urandom_range(0, 99);
			if (pick < 36)
				cmd = gsv_pkg::CMD_WRITE;
			else if (pick < 72)
				cmd = gsv_pkg::CMD_READ;
			else if (pick < 92)
				cmd = gsv_pkg::CMD_CAST;
			else if (pick < 97)
				cmd = 3'($urandom_range(5, 7));
			else if (n_clears < 7) begin
				cmd = $urandom_range(0, 1) ? gsv_pkg::CMD_CLRMAP : gsv_pkg::CMD_CLRVIEW;
				n_clears++;
			end else
				cmd = gsv_pkg::CMD_READ;
			send_cmd(cmd, x, y, r, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_queue_overflow();
		test_random(N_RANDOM - N_QUIET);
		idle_on = 1'b0;
		test_random(N_QUIET);
		wait_drained();
		repeat (50) @(posedge clk);
		$display("%0d commands accepted, %0d results checked, %0d casts (%0d with overflow)",
			n_accepted, n_checked, n_casts, n_overflows);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, answers_due.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
